// File: sv/urlpd_pkg.sv
// ============================================================================
// urlpd_pkg: shared types and helpers for the URL percent decoder.
// Holds character codes, the hex helpers and the decoded result group type.
// ============================================================================
package urlpd_pkg;

    // Character codes used by the decoder.
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [7:0] CASE_MASK  = 8'hDF;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    // Most decoded bytes one input character can produce.
    localparam int unsigned MAX_RESULTS = 3;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] count_t;
    typedef logic [1:0] index_t;

    // Decoded bytes produced by one input transaction.
    typedef struct packed {
        byte_t [MAX_RESULTS-1:0] bytes;
        count_t                  count;
        logic                    last;
    } group_t;

    // True for 0-9, a-f and A-F.
    function automatic logic is_hex(input byte_t c);
        return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) ||
               ((c >= CHAR_LC_A) && (c <= CHAR_LC_F)) ||
               ((c >= CHAR_UC_A) && (c <= CHAR_UC_F));
    endfunction

    // Nibble value of a hex character.
    function automatic logic [3:0] hex_value(input byte_t c);
        byte_t v;
        if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
            v = c - CHAR_ZERO;
        end
        else begin
            v = (c & CASE_MASK) - CHAR_UC_A + HEX_TEN;
        end
        return v[3:0];
    endfunction

endpackage

// File: sv/urlpd_decode.sv
// ============================================================================
// urlpd_decode: escape tracking and per-character decode.
// Keeps the pending-escape phase and the held hex digit, and forms the group
// of decoded bytes that each accepted character completes.
// ============================================================================
module urlpd_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  urlpd_pkg::byte_t       in_byte,
    input  logic                   in_last,
    output urlpd_pkg::group_t      group
);

    // Escape phase, one-hot.
    typedef enum logic [2:0] {
        PH_NONE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } phase_t;

    phase_t            phase_reg;
    phase_t            phase_next;
    urlpd_pkg::byte_t  held_reg;
    urlpd_pkg::byte_t  held_next;

    // Decode the character against the current phase, then flush at end of string.
    always_comb
    begin
        urlpd_pkg::byte_t [urlpd_pkg::MAX_RESULTS-1:0] r;
        urlpd_pkg::count_t                             cnt;
        logic                                          hex;
        logic                                          do_plain;
        phase_t                                        ph;
        urlpd_pkg::byte_t                              held;

        r        = '0;
        cnt      = '0;
        hex      = urlpd_pkg::is_hex(in_byte);
        do_plain = 1'b0;
        ph       = PH_NONE;
        held     = held_reg;

        unique case (phase_reg)
            PH_PCT:
            begin
                if (hex) begin
                    held = in_byte;
                    ph   = PH_DIGIT;
                end
                else begin
                    r[cnt]   = urlpd_pkg::CHAR_PCT;
                    cnt      = cnt + 2'd1;
                    do_plain = 1'b1;
                end
            end
            PH_DIGIT:
            begin
                if (hex) begin
                    r[cnt] = {urlpd_pkg::hex_value(held_reg), urlpd_pkg::hex_value(in_byte)};
                    cnt    = cnt + 2'd1;
                end
                else begin
                    r[cnt]   = urlpd_pkg::CHAR_PCT;
                    cnt      = cnt + 2'd1;
                    r[cnt]   = held_reg;
                    cnt      = cnt + 2'd1;
                    do_plain = 1'b1;
                end
            end
            default:
            begin
                do_plain = 1'b1;
            end
        endcase

        // Plain decode: percent opens an escape, plus becomes a space.
        if (do_plain) begin
            if (in_byte == urlpd_pkg::CHAR_PCT) begin
                ph = PH_PCT;
            end
            else begin
                r[cnt] = (in_byte == urlpd_pkg::CHAR_PLUS) ? urlpd_pkg::CHAR_SPACE : in_byte;
                cnt    = cnt + 2'd1;
            end
        end

        // End of string flushes a pending escape literally.
        if (in_last) begin
            if (ph == PH_PCT) begin
                r[cnt] = urlpd_pkg::CHAR_PCT;
                cnt    = cnt + 2'd1;
            end
            else if (ph == PH_DIGIT) begin
                r[cnt] = urlpd_pkg::CHAR_PCT;
                cnt    = cnt + 2'd1;
                r[cnt] = held;
                cnt    = cnt + 2'd1;
            end
            ph = PH_NONE;
        end

        group.bytes = r;
        group.count = cnt;
        group.last  = in_last;
        phase_next  = ph;
        held_next   = held;
    end

    // Escape state advances only on an accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_NONE;
            held_reg  <= '0;
        end
        else if (accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// File: sv/url_percent_decoder_unit.sv
// ============================================================================
// url_percent_decoder_unit: streaming URL percent decoder.
// Decodes one encoded character per transaction into zero to three bytes.
// ============================================================================
// Usage:
//   The input channel (in_valid/in_ready, in_byte, in_last) takes one encoded
//   character per transaction; in_last marks the final character of a string.
//   The output channel (out_valid/out_ready, out_byte, out_last) gives the
//   decoded bytes in order; out_last marks the final decoded byte of a string.
//   Plus decodes to space, percent plus two hex digits to their byte, and a
//   broken or unfinished escape is passed through literally.
//   A decoded byte reaches the output through the decoded group register
//   and then the output register, after its character is accepted.
//   Throughput: one character per cycle while each character yields at most
//   one byte and the receiver does not stall. A character that completes k
//   bytes holds them in the group register, drained one byte per cycle
//   while the receiver is ready; in_ready stays low while more than one byte
//   is left. Characters that yield no byte (an escape in progress) keep it high.
//   Reset clears the escape state and empties both registers.
//   When the receiver stalls, the output register holds its byte; characters
//   still enter the group register until it holds a byte, then in_ready falls.
// ============================================================================
module url_percent_decoder_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last
);

    urlpd_pkg::group_t                             dec_group;
    urlpd_pkg::byte_t [urlpd_pkg::MAX_RESULTS-1:0] grp_bytes_reg;
    urlpd_pkg::count_t                             grp_cnt_reg;
    urlpd_pkg::index_t                             grp_idx_reg;
    logic                                          grp_last_reg;
    logic                                          out_valid_reg;
    urlpd_pkg::byte_t                              out_byte_reg;
    logic                                          out_last_reg;
    logic                                          in_accept;
    logic                                          out_free;
    logic                                          grp_move;

    // Handshake control.
    assign out_free  = !out_valid_reg || out_ready;
    assign grp_move  = (grp_cnt_reg != 2'd0) && out_free;
    assign in_ready  = (grp_cnt_reg == 2'd0) || ((grp_cnt_reg == 2'd1) && out_free);
    assign in_accept = in_valid && in_ready;

    // Character decode and escape state.
    urlpd_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .in_byte (in_byte),
        .in_last (in_last),
        .group   (dec_group)
    );

    // Group register: decoded bytes waiting for the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            grp_cnt_reg <= '0;
            grp_idx_reg <= '0;
        end
        else if (in_accept) begin
            grp_cnt_reg <= dec_group.count;
            grp_idx_reg <= '0;
        end
        else if (grp_move) begin
            grp_cnt_reg <= grp_cnt_reg - 2'd1;
            grp_idx_reg <= grp_idx_reg + 2'd1;
        end
    end

    // Group payload.
    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            grp_bytes_reg <= dec_group.bytes;
            grp_last_reg  <= dec_group.last;
        end
    end

    // Output register: one byte per transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (grp_move) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload; the last flag rides only on the group's final byte.
    always_ff @(posedge clk)
    begin
        if (grp_move) begin
            out_byte_reg <= grp_bytes_reg[grp_idx_reg];
            out_last_reg <= grp_last_reg && (grp_cnt_reg == 2'd1);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // A new character is only taken when the group is empty or emptying.
    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (grp_cnt_reg == 2'd0 || grp_cnt_reg == 2'd1))
        else $error("input accepted while decoded bytes still queued");

    // The final character of a string always yields at least one byte.
    a_last_yields: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_last) |=> (grp_cnt_reg != 2'd0))
        else $error("end of string produced no decoded byte");

    // A byte moved out of the group shows up on the output.
    a_move_shows: assert property (@(posedge clk) disable iff (!rst_n)
        grp_move |=> out_valid_reg)
        else $error("decoded byte lost between group and output register");

endmodule

// File: verif/url_decode_checker.sv
// ============================================================================
// url_decode_checker: decoded byte predictor and scoreboard.
// Watches both channels of the URL percent decoder, predicts the decoded
// bytes of every accepted character and compares each output transaction
// field by field with the oldest prediction still outstanding.
// ============================================================================
module url_decode_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic        out_last,
    output int unsigned mismatches,
    output int unsigned awaited,
    output int unsigned decoded_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    // Escape progress of the predictor.
    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PERCENT,
        ESC_DIGIT
    } esc_phase_t;

    // One predicted output transaction.
    typedef struct packed {
        urlpd_pkg::byte_t data;
        logic             last;
    } decoded_t;

    esc_phase_t       esc_phase;
    urlpd_pkg::byte_t first_digit;
    urlpd_pkg::byte_t step_bytes[$];
    decoded_t         expected_bytes[$];

    // Hex digit test: 0-9, a-f, A-F.
    function automatic bit char_is_hex(input urlpd_pkg::byte_t c);
        return (c inside {[urlpd_pkg::CHAR_ZERO:urlpd_pkg::CHAR_NINE],
                          [urlpd_pkg::CHAR_LC_A:urlpd_pkg::CHAR_LC_F],
                          [urlpd_pkg::CHAR_UC_A:urlpd_pkg::CHAR_UC_F]});
    endfunction

    // Letters carry bit 6 and a low nibble of 1 to 6, so adding nine gives 10 to 15.
    function automatic logic [3:0] nibble_of(input urlpd_pkg::byte_t c);
        return c[3:0] + (c[6] ? 4'd9 : 4'd0);
    endfunction

    // A character decoded with no escape pending.
    function automatic void decode_plain(input urlpd_pkg::byte_t c);
        if (c == urlpd_pkg::CHAR_PCT)
        begin
            esc_phase = ESC_PERCENT;
        end
        else if (c == urlpd_pkg::CHAR_PLUS)
        begin
            step_bytes.push_back(urlpd_pkg::CHAR_SPACE);
        end
        else
        begin
            step_bytes.push_back(c);
        end
    endfunction

    // Works out the decoded bytes of one accepted character and queues them.
    function automatic void predict_char(input urlpd_pkg::byte_t c, input logic last);
        step_bytes.delete();
        case (esc_phase)
            ESC_PERCENT:
            begin
                if (char_is_hex(c))
                begin
                    first_digit = c;
                    esc_phase   = ESC_DIGIT;
                end
                else
                begin
                    // The percent sign was not an escape after all.
                    esc_phase = ESC_NONE;
                    step_bytes.push_back(urlpd_pkg::CHAR_PCT);
                    decode_plain(c);
                end
            end
            ESC_DIGIT:
            begin
                esc_phase = ESC_NONE;
                if (char_is_hex(c))
                begin
                    step_bytes.push_back({nibble_of(first_digit), nibble_of(c)});
                end
                else
                begin
                    // Percent and the held digit go out literally.
                    step_bytes.push_back(urlpd_pkg::CHAR_PCT);
                    step_bytes.push_back(first_digit);
                    decode_plain(c);
                end
            end
            default:
            begin
                esc_phase = ESC_NONE;
                decode_plain(c);
            end
        endcase

        // End of string flushes an unfinished escape.
        if (last)
        begin
            if (esc_phase == ESC_PERCENT)
            begin
                step_bytes.push_back(urlpd_pkg::CHAR_PCT);
            end
            else if (esc_phase == ESC_DIGIT)
            begin
                step_bytes.push_back(urlpd_pkg::CHAR_PCT);
                step_bytes.push_back(first_digit);
            end
            esc_phase = ESC_NONE;
        end

        foreach (step_bytes[i])
        begin
            expected_bytes.push_back('{data: step_bytes[i],
                                       last: last && (i == step_bytes.size() - 1)});
        end
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Compares one output transaction with the oldest prediction.
    task automatic check_output(input urlpd_pkg::byte_t data, input logic last);
        decoded_t want;
        decoded_seen++;
        if (expected_bytes.size() == 0)
        begin
            report_mismatch($sformatf("decoded byte 0x%02h with nothing outstanding", data));
        end
        else
        begin
            want = expected_bytes.pop_front();
            if (data !== want.data)
            begin
                report_mismatch($sformatf("out_byte 0x%02h, predicted 0x%02h",
                                          data, want.data));
            end
            if (last !== want.last)
            begin
                report_mismatch($sformatf("out_last %0b, predicted %0b on byte 0x%02h",
                                          last, want.last, want.data));
            end
        end
    endtask

    // Both channels are sampled at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_phase    = ESC_NONE;
            first_digit  = '0;
            expected_bytes.delete();
            awaited      = 0;
            mismatches   = 0;
            decoded_seen = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_char(in_byte, in_last);
            end
            if (out_valid && out_ready)
            begin
                check_output(out_byte, out_last);
            end
            awaited = expected_bytes.size();
        end
    end

endmodule

// File: verif/tb_url_percent_decoder_unit.sv
// ============================================================================
// tb_url_percent_decoder_unit: testbench top for the URL percent decoder.
// Sends directed strings for plus signs, good and broken escapes and end of
// string flushes, then random strings of mostly plain text, plus signs and
// good escapes with noise mixed in, under bursty input and a stalling receiver.
// ============================================================================
module tb_url_percent_decoder_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_CHARS = 410;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 16;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte   = '0;
    logic        in_last   = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        out_last;

    int unsigned mismatches;
    int unsigned awaited;
    int unsigned decoded_seen;
    int unsigned cycle_count  = 0;
    int unsigned chars_sent   = 0;
    int unsigned strings_sent = 0;
    int unsigned burst_left   = 4;
    int unsigned ready_mode   = 0;
    int unsigned mode_left    = 0;

    // Clock with a 2 ns period.
    always #1 clk = ~clk;

    url_percent_decoder_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    url_decode_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .mismatches   (mismatches),
        .awaited      (awaited),
        .decoded_seen (decoded_seen)
    );

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d bytes outstanding.", awaited);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: switches among always ready, coin flip, mostly stalled and periodic.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(3);
            mode_left  = $urandom_range(20, 80);
        end
        mode_left = mode_left - 1;
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(1));
            2:       out_ready <= ($urandom_range(3) == 0);
            default: out_ready <= (cycle_count % 3 != 0);
        endcase
    end

    // Presents one character and holds it until the transaction completes.
    task automatic send_char(input urlpd_pkg::byte_t c, input logic last);
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= c;
        in_last  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        chars_sent++;
        if (last)
        begin
            strings_sent++;
        end
    endtask

    // Sender pacing: bursts of random length separated by random gaps.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
        end
    endtask

    // Sends a text as one string, marking its final character.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], i == s.len() - 1);
            pace_sender();
        end
    endtask

    // Random hex digit in either case.
    function automatic urlpd_pkg::byte_t rand_hex_char();
        int unsigned v;
        v = $urandom_range(21);
        if (v < 10)
        begin
            return urlpd_pkg::CHAR_ZERO + urlpd_pkg::byte_t'(v);
        end
        else if (v < 16)
        begin
            return urlpd_pkg::CHAR_LC_A + urlpd_pkg::byte_t'(v - 10);
        end
        return urlpd_pkg::CHAR_UC_A + urlpd_pkg::byte_t'(v - 16);
    endfunction

    // Random string: mostly plain text, plus signs and good escapes, some noise.
    task automatic send_random_string();
        urlpd_pkg::byte_t text[$];
        int unsigned      pieces;
        int unsigned      kind;
        pieces = $urandom_range(1, 6);
        repeat (pieces)
        begin
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                text.push_back(urlpd_pkg::byte_t'($urandom_range(8'h20, 8'h7E)));
            end
            else if (kind < 55)
            begin
                text.push_back(urlpd_pkg::CHAR_PLUS);
            end
            else if (kind < 85)
            begin
                text.push_back(urlpd_pkg::CHAR_PCT);
                text.push_back(rand_hex_char());
                text.push_back(rand_hex_char());
            end
            else if (kind < 93)
            begin
                text.push_back(urlpd_pkg::byte_t'($urandom_range(255)));
            end
            else
            begin
                // Unfinished escape: whatever follows breaks it, or the string ends.
                text.push_back(urlpd_pkg::CHAR_PCT);
                if ($urandom_range(1))
                begin
                    text.push_back(rand_hex_char());
                end
            end
        end
        foreach (text[i])
        begin
            send_char(text[i], i == text.size() - 1);
            pace_sender();
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: plus, escapes in both cases, zero and all-ones bytes.
        send_text("+%4a");
        send_text("%00%FF");
        // Broken escape right after the percent sign.
        send_text("%g");
        // Broken escape after one digit, three bytes from one character.
        send_text("%4+");
        // A second percent sign breaks the first and starts a new escape.
        send_text("%%41");
        // End of string with a percent sign, then with percent and digit, pending.
        send_text("%");
        send_text("%F");
        // Extreme byte values as single-character strings.
        send_char(8'h00, 1'b1);
        pace_sender();
        send_char(8'hFF, 1'b1);
        pace_sender();

        // Random strings.
        while (chars_sent < RANDOM_CHARS)
        begin
            send_random_string();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Summary: %0d characters in %0d strings decoded into %0d bytes.",
                 chars_sent, strings_sent, decoded_seen);
        $display("Summary: %0d mismatches, %0d bytes left outstanding.", mismatches, awaited);
        if (mismatches == 0 && awaited == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/urlpd_pkg.sv
sv/urlpd_decode.sv
sv/url_percent_decoder_unit.sv
verif/url_decode_checker.sv
verif/tb_url_percent_decoder_unit.sv
